/* hw/rtl/afterm_pkg.sv */
// ============================================================================
// afterm_pkg
// Shared constants, register indexes and function tables for the attractor
// fabric term datapath.
// ============================================================================
package afterm_pkg;

    // Fixed-point and pipeline geometry
    localparam int FRAC_BITS_DEF = 16;
    localparam int SQRT_STEPS    = 32;
    localparam int SHAPE_LAT     = 5;
    localparam int DIV_STEPS     = 32;
    localparam int LANE_LAT      = DIV_STEPS + 2;
    localparam int NUM_AXES      = 3;

    // Configuration port
    localparam int CFG_W = 32;
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_STRENGTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_UPPER     = 3'd1;
    localparam logic [IDX_W-1:0] REG_LOWER     = 3'd2;
    localparam logic [IDX_W-1:0] REG_DAMPING   = 3'd3;
    localparam logic [IDX_W-1:0] REG_RATE      = 3'd4;
    localparam logic [IDX_W-1:0] REG_WIDTH     = 3'd5;

    localparam logic [CFG_W-1:0] RST_STRENGTH  = 32'd65536;
    localparam logic [CFG_W-1:0] RST_UPPER     = 32'd13107200;
    localparam logic [CFG_W-1:0] RST_LOWER     = 32'd655360;
    localparam logic [CFG_W-1:0] RST_DAMPING   = 32'd22937600;
    localparam logic [CFG_W-1:0] RST_RATE      = 32'd655360;
    localparam logic [CFG_W-1:0] RST_WIDTH     = 32'd327680;

    // log2(e) in Q16 and the saturated tanh value
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [16:0] TANH_SAT  = 17'd65492;

    // Per-axis side data that rides along with the radius pipeline
    typedef struct packed {
        logic [31:0] pmag;
        logic        pneg;
        logic [31:0] vmag;
        logic        vneg;
    } axis_t;

    // tanh in Q16 at steps of 1/8 over [0,4]
    function automatic logic [16:0] tanh_tab(input logic [5:0] idx);
        logic [16:0] v;
        case (idx)
            6'd0:  v = 17'd0;
            6'd1:  v = 17'd8150;
            6'd2:  v = 17'd16051;
            6'd3:  v = 17'd23485;
            6'd4:  v = 17'd30285;
            6'd5:  v = 17'd36346;
            6'd6:  v = 17'd41625;
            6'd7:  v = 17'd46131;
            6'd8:  v = 17'd49912;
            6'd9:  v = 17'd53038;
            6'd10: v = 17'd55593;
            6'd11: v = 17'd57660;
            6'd12: v = 17'd59320;
            6'd13: v = 17'd60643;
            6'd14: v = 17'd61694;
            6'd15: v = 17'd62524;
            6'd16: v = 17'd63178;
            6'd17: v = 17'd63693;
            6'd18: v = 17'd64096;
            6'd19: v = 17'd64412;
            6'd20: v = 17'd64659;
            6'd21: v = 17'd64852;
            6'd22: v = 17'd65002;
            6'd23: v = 17'd65120;
            6'd24: v = 17'd65212;
            6'd25: v = 17'd65283;
            6'd26: v = 17'd65339;
            6'd27: v = 17'd65383;
            6'd28: v = 17'd65417;
            6'd29: v = 17'd65443;
            6'd30: v = 17'd65464;
            6'd31: v = 17'd65480;
            default: v = 17'd65492;
        endcase
        return v;
    endfunction

    // 2^(-j/16) in Q16
    function automatic logic [16:0] exp2_tab(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:  v = 17'd65536;
            5'd1:  v = 17'd62757;
            5'd2:  v = 17'd60097;
            5'd3:  v = 17'd57549;
            5'd4:  v = 17'd55109;
            5'd5:  v = 17'd52772;
            5'd6:  v = 17'd50535;
            5'd7:  v = 17'd48393;
            5'd8:  v = 17'd46341;
            5'd9:  v = 17'd44376;
            5'd10: v = 17'd42495;
            5'd11: v = 17'd40693;
            5'd12: v = 17'd38968;
            5'd13: v = 17'd37316;
            5'd14: v = 17'd35734;
            5'd15: v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/afterm_sqrt.sv */
// ============================================================================
// afterm_sqrt
// Pipelined integer square root, one result bit per stage.
// ============================================================================
module afterm_sqrt
(
    input  logic        clk,
    input  logic        adv,
    input  logic [63:0] sum,
    output logic [31:0] root
);

    localparam int N = afterm_pkg::SQRT_STEPS;

    logic [34:0] rem_reg   [N];
    logic [31:0] root_reg  [N];
    logic [63:0] rest_reg  [N];

    logic [34:0] rem_next  [N];
    logic [31:0] root_next [N];
    logic [63:0] rest_next [N];

    // One digit per stage: shift in two bits, try to subtract 4*root+1
    always_comb
    begin
        logic [34:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] rest_in;
        logic [34:0] trial;
        for (int k = 0; k < N; k++)
        begin
            if (k == 0)
            begin
                rem_in  = '0;
                root_in = '0;
                rest_in = sum;
            end
            else
            begin
                rem_in  = rem_reg[k-1];
                root_in = root_reg[k-1];
                rest_in = rest_reg[k-1];
            end
            rem_next[k]  = {rem_in[32:0], rest_in[63:62]};
            trial        = {1'b0, root_in, 2'b01};
            rest_next[k] = {rest_in[61:0], 2'b00};
            if (rem_next[k] >= trial)
            begin
                rem_next[k]  = rem_next[k] - trial;
                root_next[k] = {root_in[30:0], 1'b1};
            end
            else
            begin
                root_next[k] = {root_in[30:0], 1'b0};
            end
        end
    end

    // Advance the stages together
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < N; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rest_reg[k] <= rest_next[k];
            end
        end
    end

    assign root = root_reg[N-1];

endmodule

/* hw/rtl/afterm_shape.sv */
// ============================================================================
// afterm_shape
// Radial shaping: tanh gain and exp falloff from the radius, five stages.
// ============================================================================
module afterm_shape
#(
    parameter int FRAC_BITS = afterm_pkg::FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        adv,
    input  logic [31:0] r,
    input  logic [31:0] strength,
    input  logic [31:0] slope_gain,
    input  logic [31:0] basis_width,
    output logic [31:0] g,
    output logic [16:0] e,
    output logic [31:0] r_out
);

    localparam int DN = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int UP = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int WN = FRAC_BITS + 3;
    localparam int SW = 2 * FRAC_BITS + 6;
    localparam int L  = afterm_pkg::SHAPE_LAT;

    // radius carried alongside
    logic [31:0] r_reg [L];

    // stage 1
    logic [63:0] ur_reg, wr_reg;
    // stage 2
    logic        tbig_reg;
    logic [16:0] t0_reg;
    logic [15:0] tdel_reg;
    logic [12:0] tfr_reg;
    logic        wbig_reg;
    logic [SW-1:0] s_reg;
    // stage 3
    logic [16:0] tanh_reg;
    logic        ebig3_reg;
    logic [37:0] y_reg;
    // stage 4
    logic [31:0] g4_reg;
    logic        ebig4_reg;
    logic [16:0] e0_reg;
    logic [16:0] edel_reg;
    logic [11:0] sub_reg;
    logic [4:0]  nsh_reg;
    // stage 5
    logic [31:0] g5_reg;
    logic [16:0] e5_reg;

    logic [63:0]   u, w;
    logic [17:0]   u16;
    logic [5:0]    tidx;
    logic [WN-1:0] wn;
    logic [SW-1:0] wsq;
    logic [SW-1:0] s_nx;
    logic [28:0]   tprod;
    logic [20:0]   s16;
    logic [37:0]   y_nx;
    logic [48:0]   gprod;
    logic [4:0]    j;
    logic [28:0]   eprod;
    logic [16:0]   ev;

    always_comb
    begin
        // tanh index and fraction in Q16
        u    = ur_reg >> FRAC_BITS;
        u16  = 18'((u >> DN) << UP);
        tidx = {1'b0, u16[17:13]};
        // basis argument squared, back to FRAC_BITS fraction bits
        w    = wr_reg >> FRAC_BITS;
        wn   = w[WN-1:0];
        wsq  = wn * wn;
        s_nx = wsq >> FRAC_BITS;
        // tanh interpolation
        tprod = tdel_reg * tfr_reg;
        // exp2 exponent, y in Q32 before the final shift
        s16  = 21'((s_reg >> DN) << UP);
        y_nx = s16 * afterm_pkg::LOG2E_Q16;
        // gain
        gprod = strength * tanh_reg;
        j     = {1'b0, y_reg[31:28]};
        // exp interpolation
        eprod = edel_reg * sub_reg;
        ev    = e0_reg - 17'(eprod >> 12);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg[0] <= r;
            for (int k = 1; k < L; k++)
            begin
                r_reg[k] <= r_reg[k-1];
            end

            // stage 1: scale radius
            ur_reg <= slope_gain * r;
            wr_reg <= basis_width * r;

            // stage 2: table lookup and square
            tbig_reg <= (u >= (64'd4 << FRAC_BITS));
            t0_reg   <= afterm_pkg::tanh_tab(tidx);
            tdel_reg <= 16'(afterm_pkg::tanh_tab(tidx + 6'd1) - afterm_pkg::tanh_tab(tidx));
            tfr_reg  <= u16[12:0];
            wbig_reg <= (w >= (64'd6 << FRAC_BITS));
            s_reg    <= s_nx;

            // stage 3: interpolate tanh, form exp2 exponent
            tanh_reg  <= tbig_reg ? afterm_pkg::TANH_SAT : t0_reg + 17'(tprod >> 13);
            ebig3_reg <= wbig_reg || (s_reg >= (SW'(32) << FRAC_BITS));
            y_reg     <= y_nx;

            // stage 4: gain and exp2 lookup
            g4_reg    <= 32'(gprod >> 16);
            ebig4_reg <= ebig3_reg || y_reg[37];
            e0_reg    <= afterm_pkg::exp2_tab(j);
            edel_reg  <= afterm_pkg::exp2_tab(j) - afterm_pkg::exp2_tab(j + 5'd1);
            sub_reg   <= y_reg[27:16];
            nsh_reg   <= y_reg[36:32];

            // stage 5: interpolate and shift exp
            g5_reg <= g4_reg;
            e5_reg <= ebig4_reg ? 17'd0 : (ev >> nsh_reg);
        end
    end

    assign g     = g5_reg;
    assign e     = e5_reg;
    assign r_out = r_reg[L-1];

endmodule

/* hw/rtl/afterm_lane.sv */
// ============================================================================
// afterm_lane
// One axis: gradient divide by radius, damping, sum and saturate.
// ============================================================================
module afterm_lane
#(
    parameter int FRAC_BITS = afterm_pkg::FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               adv,
    input  logic [31:0]        g,
    input  logic [31:0]        r,
    input  afterm_pkg::axis_t  ax,
    input  logic [31:0]        damping_gain,
    output logic [31:0]        accel
);

    localparam int N  = afterm_pkg::DIV_STEPS;
    localparam int DW = 64 - FRAC_BITS;
    localparam int AW = DW + 2;

    // stage 1
    logic [63:0]   num_reg;
    logic [DW-1:0] dm1_reg;
    logic [31:0]   r1_reg;
    logic          pn1_reg, vn1_reg;

    // divider stages
    logic [31:0]   rem_reg  [N];
    logic [31:0]   q_reg    [N];
    logic [31:0]   lo_reg   [N];
    logic [31:0]   dr_reg   [N];
    logic [DW-1:0] dm_reg   [N];
    logic          pn_reg   [N];
    logic          vn_reg   [N];

    logic [31:0]   rem_next [N];
    logic [31:0]   q_next   [N];
    logic [31:0]   lo_next  [N];

    logic [31:0]   acc_reg;

    logic [63:0]   dprod;
    logic signed [AW-1:0] a_g, a_d, acc;

    // Restoring divide, one quotient bit per stage
    always_comb
    begin
        logic [31:0] rem_in;
        logic [31:0] q_in;
        logic [31:0] lo_in;
        logic [31:0] dv;
        logic [32:0] t;
        for (int k = 0; k < N; k++)
        begin
            if (k == 0)
            begin
                rem_in = num_reg[63:32];
                q_in   = '0;
                lo_in  = num_reg[31:0];
                dv     = r1_reg;
            end
            else
            begin
                rem_in = rem_reg[k-1];
                q_in   = q_reg[k-1];
                lo_in  = lo_reg[k-1];
                dv     = dr_reg[k-1];
            end
            t          = {rem_in, lo_in[31]};
            lo_next[k] = {lo_in[30:0], 1'b0};
            if (t >= {1'b0, dv})
            begin
                rem_next[k] = 32'(t - {1'b0, dv});
                q_next[k]   = {q_in[30:0], 1'b1};
            end
            else
            begin
                rem_next[k] = t[31:0];
                q_next[k]   = {q_in[30:0], 1'b0};
            end
        end
    end

    // Combine: -grad - damp, zero gradient at zero radius
    always_comb
    begin
        dprod = damping_gain * ax.vmag;
        a_g   = (dr_reg[N-1] == '0) ? '0 : AW'(q_reg[N-1]);
        a_d   = AW'(dm_reg[N-1]);
        acc   = (pn_reg[N-1] ? a_g : -a_g) + (vn_reg[N-1] ? a_d : -a_d);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1: products
            num_reg <= g * ax.pmag;
            dm1_reg <= DW'(dprod >> FRAC_BITS);
            r1_reg  <= r;
            pn1_reg <= ax.pneg;
            vn1_reg <= ax.vneg;

            // divider stages
            for (int k = 0; k < N; k++)
            begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
                lo_reg[k]  <= lo_next[k];
                if (k == 0)
                begin
                    dr_reg[k] <= r1_reg;
                    dm_reg[k] <= dm1_reg;
                    pn_reg[k] <= pn1_reg;
                    vn_reg[k] <= vn1_reg;
                end
                else
                begin
                    dr_reg[k] <= dr_reg[k-1];
                    dm_reg[k] <= dm_reg[k-1];
                    pn_reg[k] <= pn_reg[k-1];
                    vn_reg[k] <= vn_reg[k-1];
                end
            end

            // saturate to 32-bit signed
            if ((&acc[AW-1:31]) || !(|acc[AW-1:31]))
                acc_reg <= acc[31:0];
            else if (acc[AW-1])
                acc_reg <= 32'h8000_0000;
            else
                acc_reg <= 32'h7FFF_FFFF;
        end
    end

    assign accel = acc_reg;

endmodule

/* hw/rtl/attractor_fabric_term_core.sv */
// ============================================================================
// attractor_fabric_term_core
// Geometric fabric attractor term: acceleration and metric per sample.
// ============================================================================
// Usage:
//   Input channel: in_valid/in_stall with pos_x..vel_z; a word is taken at
//   a clock edge with in_valid high and in_stall low.
//   Output channel: out_valid/out_stall with accel_x..z and metric_coeff;
//   exactly one result word per input word, in order.
//   Configuration: wr_en/wr_index/wr_data writes one of six registers;
//   write only while no words are in flight.
//   One word is accepted every cycle while in_stall is low. The pipeline is
//   built from the 32-stage square root, the five-stage tanh/exp shaper and
//   the 32-stage divider in each axis lane.
//   When out_stall holds a valid result the whole pipeline freezes and
//   in_stall rises in the same cycle; nothing is dropped.
//   Reset clears all pipeline valid bits and loads the register defaults.
// ============================================================================
module attractor_fabric_term_core
#(
    parameter int FRAC_BITS = afterm_pkg::FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [31:0]            pos_x,
    input  logic signed [31:0]            pos_y,
    input  logic signed [31:0]            pos_z,
    input  logic signed [31:0]            vel_x,
    input  logic signed [31:0]            vel_y,
    input  logic signed [31:0]            vel_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [31:0]            accel_x,
    output logic signed [31:0]            accel_y,
    output logic signed [31:0]            accel_z,
    output logic [31:0]                   metric_coeff,
    input  logic                          wr_en,
    input  logic [afterm_pkg::IDX_W-1:0]  wr_index,
    input  logic [afterm_pkg::CFG_W-1:0]  wr_data
);

    localparam int NA     = afterm_pkg::NUM_AXES;
    localparam int PV_DLY = 2 + afterm_pkg::SQRT_STEPS + afterm_pkg::SHAPE_LAT;
    localparam int E_DLY  = afterm_pkg::LANE_LAT - 1;
    localparam int DEPTH  = 3 + afterm_pkg::SQRT_STEPS + afterm_pkg::SHAPE_LAT
                          + afterm_pkg::LANE_LAT + 1;

    // configuration
    logic [31:0] strength_reg, upper_reg, lower_reg, damping_reg, rate_reg, width_reg;

    // control
    logic             adv;
    logic [DEPTH-1:0] vld_reg;

    // datapath
    afterm_pkg::axis_t ax_reg  [NA];
    afterm_pkg::axis_t pv_reg  [PV_DLY][NA];
    logic [63:0]       sq_reg  [NA];
    logic [63:0]       sum_reg;
    logic [31:0]       r_root;
    logic [31:0]       g_sh, r_sh;
    logic [16:0]       e_sh;
    logic [16:0]       e_dly_reg [E_DLY];
    logic [32:0]       term_reg;
    logic              tneg_reg;
    logic [31:0]       lane_acc [NA];
    logic [31:0]       ax_out_reg [NA];
    logic [31:0]       coeff_reg;

    logic signed [31:0] pin [NA];
    logic signed [31:0] vin [NA];
    logic signed [32:0] diff;
    logic [31:0]        dm;
    logic [49:0]        tprod;
    logic signed [34:0] coeff;

    // Freeze everything while a result waits on a stalled receiver
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    always_comb
    begin
        pin[0] = pos_x;
        pin[1] = pos_y;
        pin[2] = pos_z;
        vin[0] = vel_x;
        vin[1] = vel_y;
        vin[2] = vel_z;
        diff   = $signed({1'b0, upper_reg}) - $signed({1'b0, lower_reg});
        dm     = diff[32] ? 32'(-diff) : diff[31:0];
        tprod  = dm * e_dly_reg[E_DLY-1];
        coeff  = tneg_reg ? $signed({3'b0, lower_reg}) - $signed({2'b0, term_reg})
                          : $signed({3'b0, lower_reg}) + $signed({2'b0, term_reg});
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_reg <= afterm_pkg::RST_STRENGTH;
            upper_reg    <= afterm_pkg::RST_UPPER;
            lower_reg    <= afterm_pkg::RST_LOWER;
            damping_reg  <= afterm_pkg::RST_DAMPING;
            rate_reg     <= afterm_pkg::RST_RATE;
            width_reg    <= afterm_pkg::RST_WIDTH;
        end
        else if (wr_en)
        begin
            case (wr_index)
                afterm_pkg::REG_STRENGTH: strength_reg <= wr_data;
                afterm_pkg::REG_UPPER:    upper_reg    <= wr_data;
                afterm_pkg::REG_LOWER:    lower_reg    <= wr_data;
                afterm_pkg::REG_DAMPING:  damping_reg  <= wr_data;
                afterm_pkg::REG_RATE:     rate_reg     <= wr_data;
                afterm_pkg::REG_WIDTH:    width_reg    <= wr_data;
                default: ;
            endcase
        end
    end

    // Valid bits advance with the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    assign out_valid = vld_reg[DEPTH-1];

    // Front end: magnitudes, squares, sum; side data delay line
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NA; i++)
            begin
                ax_reg[i].pmag <= pin[i][31] ? 32'(-pin[i]) : pin[i];
                ax_reg[i].pneg <= pin[i][31];
                ax_reg[i].vmag <= vin[i][31] ? 32'(-vin[i]) : vin[i];
                ax_reg[i].vneg <= vin[i][31];
                sq_reg[i]      <= ax_reg[i].pmag * ax_reg[i].pmag;
                pv_reg[0][i]   <= ax_reg[i];
                for (int k = 1; k < PV_DLY; k++)
                begin
                    pv_reg[k][i] <= pv_reg[k-1][i];
                end
            end
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    afterm_sqrt u_sqrt
    (
        .clk  (clk),
        .adv  (adv),
        .sum  (sum_reg),
        .root (r_root)
    );

    afterm_shape #(.FRAC_BITS(FRAC_BITS)) u_shape
    (
        .clk         (clk),
        .adv         (adv),
        .r           (r_root),
        .strength    (strength_reg),
        .slope_gain  (rate_reg),
        .basis_width (width_reg),
        .g           (g_sh),
        .e           (e_sh),
        .r_out       (r_sh)
    );

    for (genvar i = 0; i < NA; i++)
    begin : g_lane
        afterm_lane #(.FRAC_BITS(FRAC_BITS)) u_lane
        (
            .clk          (clk),
            .adv          (adv),
            .g            (g_sh),
            .r            (r_sh),
            .ax           (pv_reg[PV_DLY-1][i]),
            .damping_gain (damping_reg),
            .accel        (lane_acc[i])
        );
    end

    // Metric path held level with the lanes, then merge into the output word
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_dly_reg[0] <= e_sh;
            for (int k = 1; k < E_DLY; k++)
            begin
                e_dly_reg[k] <= e_dly_reg[k-1];
            end
            term_reg <= 33'(tprod >> 16);
            tneg_reg <= diff[32];

            for (int i = 0; i < NA; i++)
            begin
                ax_out_reg[i] <= lane_acc[i];
            end
            if (coeff[34])
                coeff_reg <= '0;
            else if (|coeff[33:32])
                coeff_reg <= 32'hFFFF_FFFF;
            else
                coeff_reg <= coeff[31:0];
        end
    end

    assign accel_x      = ax_out_reg[0];
    assign accel_y      = ax_out_reg[1];
    assign accel_z      = ax_out_reg[2];
    assign metric_coeff = coeff_reg;

endmodule

/* hw/rtl/afterm_checker.sv */
// ============================================================================
// afterm_checker
// Port-level checks on the attractor term core's handshakes.
// ============================================================================
module afterm_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_stall,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] accel_x,
    input  logic [31:0] metric_coeff
);

    // Input backpressure comes only from a held result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("in_stall does not match a held output word");

    // A new result appears only while the pipeline advances, never while it is frozen
    a_rise_adv: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_stall))
        else $error("out_valid rose while the pipeline was frozen");

    // Hold the word while the receiver stalls
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped under stall");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(accel_x) && $stable(metric_coeff))
        else $error("output word changed under stall");

endmodule

bind attractor_fabric_term_core afterm_checker u_afterm_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .accel_x      (accel_x),
    .metric_coeff (metric_coeff)
);
